// ----- design/uesc_pkg.sv -----
// Package for the backslash-u escape decoder.
// Holds the phase encoding, the result burst type, character constants and
// the hex digit helper. No dependencies.
package uesc_pkg;

   // Widths and limits.
   localparam int UNIT_W    = 16;
   localparam int MAX_UNITS = 5;
   localparam int COUNT_W   = 3;
   localparam int ACCUM_W   = 12;

   // Code units with special meaning.
   localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [UNIT_W-1:0] CH_U         = 16'h0075;
   localparam logic [UNIT_W-1:0] CH_DIG_LO    = 16'h0030;
   localparam logic [UNIT_W-1:0] CH_DIG_HI    = 16'h0039;
   localparam logic [UNIT_W-1:0] CH_UPPER_LO  = 16'h0041;
   localparam logic [UNIT_W-1:0] CH_UPPER_HI  = 16'h0046;
   localparam logic [UNIT_W-1:0] CH_LOWER_LO  = 16'h0061;
   localparam logic [UNIT_W-1:0] CH_LOWER_HI  = 16'h0066;

   typedef logic [UNIT_W-1:0]  unit_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Escape progress: idle, backslash seen, backslash-u seen, then one,
   // two and three digits seen.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SLASH = 3'd1,
      PH_U     = 3'd2,
      PH_D1    = 3'd3,
      PH_D2    = 3'd4,
      PH_D3    = 3'd5
   } phase_type;

   // The result units caused by one input beat, oldest in entry 0.
   typedef struct packed {
      unit_type [MAX_UNITS-1:0] units;
      count_type                count;
      logic                     last;
   } burst_type;

   // Value of a hex digit unit; anything else counts as zero.
   function automatic logic [3:0] hex_value(input unit_type c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
         v = c[3:0];
      end else if ((c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
                   (c >= CH_LOWER_LO && c <= CH_LOWER_HI)) begin
         v = 4'(c[3:0] + 4'd9);
      end
      return v;
   endfunction

endpackage

// ----- design/uesc_decode.sv -----
// Input register and escape decoding for the backslash-u decoder.
// Turns each registered input beat into a burst of result units.
// Depends on uesc_pkg.
module uesc_decode
   import uesc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  unit_type  in_char,
   input  logic      in_last,
   input  logic      load_ok,
   output logic      burst_valid,
   output burst_type burst
);

   logic                   hold_ff;
   logic                   hold_in;
   unit_type               char_ff;
   logic                   last_ff;
   phase_type              phase_ff;
   phase_type              phase_in;
   logic [ACCUM_W-1:0]     accum_ff;
   logic [ACCUM_W-1:0]     accum_in;
   unit_type [2:0]         pend_ff;
   unit_type [2:0]         pend_in;
   logic                   fire;
   logic                   take;
   logic [3:0]             digit;
   phase_type              base_phase;

   // The held beat is decoded once the result buffer can take its burst.
   assign fire        = hold_ff && load_ok;
   assign in_ready    = !hold_ff || load_ok;
   assign take        = in_valid && in_ready;
   assign hold_in     = take ? 1'b1 : (fire ? 1'b0 : hold_ff);
   assign burst_valid = fire;
   assign digit       = hex_value(char_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      if (take) begin
         char_ff <= in_char;
         last_ff <= in_last;
      end
   end

   // Escape state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
      if (fire) begin
         pend_ff <= pend_in;
      end
   end

   // Decode one unit against the current phase, then flush at end of text.
   always_comb begin
      burst       = '0;
      burst.last  = last_ff;
      pend_in     = pend_ff;
      accum_in    = accum_ff;
      base_phase  = PH_IDLE;
      case (phase_ff)
         PH_SLASH: begin
            if (char_ff == CH_U) begin
               base_phase = PH_U;
               accum_in   = '0;
            end else begin
               burst.units[0] = CH_BACKSLASH;
               if (char_ff == CH_BACKSLASH) begin
                  base_phase  = PH_SLASH;
                  burst.count = 3'd1;
               end else begin
                  burst.units[1] = char_ff;
                  burst.count    = 3'd2;
               end
            end
         end
         PH_U: begin
            pend_in[0] = char_ff;
            accum_in   = ACCUM_W'(digit);
            base_phase = PH_D1;
         end
         PH_D1: begin
            pend_in[1] = char_ff;
            accum_in   = {accum_ff[ACCUM_W-5:0], digit};
            base_phase = PH_D2;
         end
         PH_D2: begin
            pend_in[2] = char_ff;
            accum_in   = {accum_ff[ACCUM_W-5:0], digit};
            base_phase = PH_D3;
         end
         PH_D3: begin
            burst.units[0] = {accum_ff, digit};
            burst.count    = 3'd1;
            accum_in       = '0;
         end
         default: begin
            if (char_ff == CH_BACKSLASH) begin
               base_phase = PH_SLASH;
            end else begin
               burst.units[0] = char_ff;
               burst.count    = 3'd1;
            end
         end
      endcase

      phase_in = base_phase;
      if (last_ff) begin
         phase_in = PH_IDLE;
         accum_in = '0;
         // A lone pending backslash follows whatever was already emitted.
         if (base_phase == PH_SLASH) begin
            burst.units[burst.count] = CH_BACKSLASH;
            burst.count              = 3'(burst.count + 3'd1);
         end else if (base_phase != PH_IDLE) begin
            // Inside backslash-u nothing else was emitted this beat.
            burst.units[0] = CH_BACKSLASH;
            burst.units[1] = CH_U;
            burst.units[2] = pend_in[0];
            burst.units[3] = pend_in[1];
            burst.units[4] = pend_in[2];
            case (base_phase)
               PH_U:    burst.count = 3'd2;
               PH_D1:   burst.count = 3'd3;
               PH_D2:   burst.count = 3'd4;
               PH_D3:   burst.count = 3'd5;
               default: burst.count = 3'd0;
            endcase
         end
      end
   end

endmodule

// ----- design/uesc_burst.sv -----
// Result buffer for the backslash-u decoder: holds one burst of units and
// hands them out one per cycle while out_ready is high. Depends on uesc_pkg.
module uesc_burst
   import uesc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      burst_valid,
   input  burst_type burst,
   output logic      load_ok,
   output logic      out_valid,
   input  logic      out_ready,
   output unit_type  out_char,
   output logic      out_last
);

   unit_type [MAX_UNITS-1:0] units_ff;
   count_type                count_ff;
   logic                     last_ff;
   logic                     take;

   assign out_valid = (count_ff != '0);
   assign take      = out_valid && out_ready;
   assign load_ok   = (count_ff == '0) || (count_ff == 3'd1 && take);
   assign out_char  = units_ff[0];
   assign out_last  = last_ff && (count_ff == 3'd1);

   // Load a new burst or shift the remaining units toward the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (burst_valid && load_ok) begin
         count_ff <= burst.count;
      end else if (take) begin
         count_ff <= 3'(count_ff - 3'd1);
      end
      if (burst_valid && load_ok) begin
         units_ff <= burst.units;
         last_ff  <= burst.last;
      end else if (take) begin
         units_ff <= {unit_type'(0), units_ff[MAX_UNITS-1:1]};
      end
   end

endmodule

// ----- design/unicode_escape_decoder.sv -----
// Backslash-u escape decoder, top level. An accepted beat is registered,
// then decoded into the rsp_ result buffer once that can take its burst.
// Throughput: one beat per cycle while each input beat yields at most one
// unit and the receiver is ready; a beat yielding more units holds the
// input until the buffer, draining one unit per cycle, is down to its last.
// Synchronous active-high reset clears valid flags and state.
module unicode_escape_decoder
   import uesc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] char_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] char_out
   output logic        rsp_tlast
);

   logic      load_ok;
   logic      burst_valid;
   burst_type burst;

   // Input register and decode.
   uesc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_char     (req_tdata),
      .in_last     (req_tlast),
      .load_ok     (load_ok),
      .burst_valid (burst_valid),
      .burst       (burst)
   );

   // Result buffer.
   uesc_burst u_burst (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (burst),
      .load_ok     (load_ok),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_char    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule
